// ----- rtl/core/hemicube_form_factor_accumulator_macros.svh -----
// Assertion macros used by the accumulator control FSM.
`ifndef HEMICUBE_FORM_FACTOR_ACCUMULATOR_MACROS_SVH
`define HEMICUBE_FORM_FACTOR_ACCUMULATOR_MACROS_SVH

`ifndef SYNTHESIS

`define HFFA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("hffa assertion failed");

`define HFFA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("hffa assertion failed");

`else

`define HFFA_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define HFFA_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/core/hffa_pkg.sv -----
`default_nettype none

package hffa_pkg;

	localparam int DEF_MAX_RES     = 128;
	localparam int DEF_MAX_PATCHES = 4096;

	localparam int RES_W     = 8;
	localparam int COLOR_W   = 24;
	localparam int PCOUNT_W  = 13;
	localparam int COORD_W   = 7;
	localparam int ENTRY_W   = 12;
	localparam int WEIGHT_W  = 32;
	localparam int SUM_W     = 36;
	localparam int STATUS_W  = 2;

	localparam int IN_DATA_W  = 88;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 40;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [RES_W-1:0] RES_RESET = 8'd128;

	localparam logic [1:0] REG_RESOLUTION  = 2'd0;
	localparam logic [1:0] REG_BACKGROUND  = 2'd1;
	localparam logic [1:0] REG_PATCH_COUNT = 2'd2;

	typedef enum logic [1:0] {
		CMD_CLEAR,
		CMD_LOAD,
		CMD_ACCUM,
		CMD_READ
	} hffa_cmd_t;

	typedef enum logic [1:0] {
		STS_DONE,
		STS_BACKGROUND,
		STS_BAD_ID,
		STS_BAD_POS
	} hffa_status_t;

	typedef enum logic [2:0] {
		S_INIT_CLR,
		S_IDLE,
		S_EXEC,
		S_CMD_CLR,
		S_FINISH
	} hffa_state_t;

	typedef struct packed {
		logic [RES_W-1:0]    resolution;
		logic [COLOR_W-1:0]  background_color;
		logic [PCOUNT_W-1:0] patch_count;
	} hffa_cfg_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic finish;
		logic clr_run;
	} hffa_ctl_t;

	typedef struct packed {
		hffa_cmd_t cmd;
		logic      clr_last;
		logic      out_free;
	} hffa_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/hffa_ram.sv -----
`default_nettype none

module hffa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/hffa_regs.sv -----
`default_nettype none

module hffa_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [hffa_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [hffa_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [hffa_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	output hffa_pkg::hffa_cfg_t               cfg
);

	import hffa_pkg::*;

	logic      wr_en;
	hffa_cfg_t cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.resolution       <= RES_RESET;
			cfg_q.background_color <= '0;
			cfg_q.patch_count      <= '0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_RESOLUTION:  cfg_q.resolution       <= pwdata[RES_W-1:0];
				REG_BACKGROUND:  cfg_q.background_color <= pwdata[COLOR_W-1:0];
				REG_PATCH_COUNT: cfg_q.patch_count      <= pwdata[PCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_RESOLUTION:  prdata = APB_DATA_W'(cfg_q.resolution);
			REG_BACKGROUND:  prdata = APB_DATA_W'(cfg_q.background_color);
			REG_PATCH_COUNT: prdata = APB_DATA_W'(cfg_q.patch_count);
			default:         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/hffa_ctrl.sv -----
`default_nettype none
`include "hemicube_form_factor_accumulator_macros.svh"

module hffa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output hffa_pkg::hffa_ctl_t  ctl,
	input  hffa_pkg::hffa_sts_t  sts
);

	import hffa_pkg::*;

	hffa_state_t state_q;
	hffa_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_INIT_CLR: begin
				ctl.clr_run = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = (sts.cmd == CMD_CLEAR) ? S_CMD_CLR : S_FINISH;
			end
			S_CMD_CLR: begin
				ctl.clr_run = 1'b1;
				if (sts.clr_last) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					ctl.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	`HFFA_ASSERT_NXT(a_accept_to_exec, clk, arst_n, ctl.accept, state_q == S_EXEC)
	`HFFA_ASSERT_NXT(a_exec_next, clk, arst_n, state_q == S_EXEC, state_q == S_FINISH || state_q == S_CMD_CLR)
	`HFFA_ASSERT_IMP(a_one_command, clk, arst_n, 1'b1, $onehot0(ctl))
	`HFFA_ASSERT_NXT(a_finish_to_idle, clk, arst_n, ctl.finish, state_q == S_IDLE)

endmodule

`default_nettype wire

// ----- rtl/core/hffa_dpath.sv -----
`default_nettype none

module hffa_dpath #(
	parameter int MAX_RES     = hffa_pkg::DEF_MAX_RES,
	parameter int MAX_PATCHES = hffa_pkg::DEF_MAX_PATCHES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  hffa_pkg::hffa_ctl_t                ctl,
	output hffa_pkg::hffa_sts_t                sts,
	input  hffa_pkg::hffa_cfg_t                cfg,
	input  logic [hffa_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic [hffa_pkg::IN_USER_W-1:0]     s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [hffa_pkg::OUT_DATA_W-1:0]    m_tdata
);

	import hffa_pkg::*;

	localparam int QD  = (MAX_RES / 2) * (MAX_RES / 2);
	localparam int QAW = $clog2(QD);
	localparam int PW  = $clog2(MAX_PATCHES);

	hffa_cmd_t            cmd_q;
	logic                 face_q;
	logic [COORD_W-1:0]   row_q;
	logic [COORD_W-1:0]   col_q;
	logic [COLOR_W-1:0]   color_q;
	logic [ENTRY_W-1:0]   entry_q;
	logic [WEIGHT_W-1:0]  weight_q;

	logic [RES_W-1:0]     res_eff;
	logic [COORD_W-1:0]   half;
	logic [RES_W-1:0]     col_limit;
	logic                 slot_ok;
	logic                 pos_bad;
	logic                 entry_ok;
	logic [COORD_W-1:0]   fold_row;
	logic [COORD_W-1:0]   fold_col;
	logic [14:0]          idx;
	logic                 idx_ok;
	logic [PW-1:0]        slot;
	hffa_status_t         status_d;
	logic                 do_acc_d;
	logic                 rd_ok_d;

	hffa_status_t         status_s2;
	logic                 do_acc_s2;
	logic                 rd_ok_s2;
	logic                 face_s2;
	logic [PW-1:0]        slot_s2;

	logic [PW-1:0]        clr_cnt_q;
	logic                 clr_last;

	logic [SUM_W-1:0]     sum_rd;
	logic [WEIGHT_W-1:0]  top_rd;
	logic [WEIGHT_W-1:0]  side_rd;
	logic [WEIGHT_W-1:0]  w_sel;
	logic [SUM_W:0]       acc;
	logic [SUM_W-1:0]     new_sum;
	logic                 sum_we;
	logic [PW-1:0]        sum_waddr;
	logic [SUM_W-1:0]     sum_wdata;
	logic                 load_we;

	logic                 m_tvalid_q;
	hffa_status_t         out_status_q;
	logic [SUM_W-1:0]     out_sum_q;

	function automatic logic [COORD_W-1:0] fold_coord(
		input logic [COORD_W-1:0] n,
		input logic [RES_W-1:0]   res,
		input logic [COORD_W-1:0] hf
	);
		logic [RES_W-1:0] mirror;
		mirror = res - 8'd1 - {1'b0, n};
		return (n < hf) ? n : mirror[COORD_W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q    <= hffa_cmd_t'(s_tuser[1:0]);
			face_q   <= s_tuser[2];
			row_q    <= s_tdata[6:0];
			col_q    <= s_tdata[13:7];
			color_q  <= s_tdata[37:14];
			entry_q  <= s_tdata[49:38];
			weight_q <= s_tdata[81:50];
		end
	end

	assign res_eff   = (32'(cfg.resolution) > 32'(MAX_RES)) ? RES_W'(MAX_RES) : cfg.resolution;
	assign half      = res_eff[RES_W-1:1];
	assign col_limit = face_q ? {1'b0, half} : res_eff;
	assign pos_bad   = ({1'b0, row_q} >= res_eff) || ({1'b0, col_q} >= col_limit);
	assign slot_ok   = (color_q != '0) && (32'(color_q) <= 32'(cfg.patch_count))
	                   && (32'(color_q) <= 32'(MAX_PATCHES));
	assign slot      = PW'(color_q - 24'd1);
	assign entry_ok  = 32'(entry_q) < 32'(QD);
	assign fold_row  = fold_coord(row_q, res_eff, half);
	assign fold_col  = fold_coord(col_q, res_eff, half);
	assign idx       = 15'(fold_row) * 15'(half) + 15'(fold_col);
	assign idx_ok    = 32'(idx) < 32'(QD);

	always_comb begin
		status_d = STS_DONE;
		do_acc_d = 1'b0;
		rd_ok_d  = 1'b0;
		case (cmd_q)
			CMD_CLEAR: status_d = STS_DONE;
			CMD_LOAD: begin
				if (!entry_ok) begin
					status_d = STS_BAD_POS;
				end
			end
			CMD_ACCUM: begin
				if (color_q == cfg.background_color) begin
					status_d = STS_BACKGROUND;
				end else if (!slot_ok) begin
					status_d = STS_BAD_ID;
				end else if (pos_bad || !idx_ok) begin
					status_d = STS_BAD_POS;
				end else begin
					do_acc_d = 1'b1;
				end
			end
			CMD_READ: begin
				if (!slot_ok) begin
					status_d = STS_BAD_ID;
				end else begin
					rd_ok_d = 1'b1;
				end
			end
			default: status_d = STS_DONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			status_s2 <= status_d;
			do_acc_s2 <= do_acc_d;
			rd_ok_s2  <= rd_ok_d;
			face_s2   <= face_q;
			slot_s2   <= slot;
		end
	end

	assign clr_last = (clr_cnt_q == PW'(MAX_PATCHES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (ctl.clr_run) begin
			clr_cnt_q <= clr_last ? '0 : clr_cnt_q + 1'b1;
		end
	end

	assign load_we = ctl.exec && (cmd_q == CMD_LOAD) && entry_ok;

	hffa_ram #(
		.WIDTH (WEIGHT_W),
		.DEPTH (QD)
	) u_top_ram (
		.clk   (clk),
		.we    (load_we && !face_q),
		.waddr (QAW'(entry_q)),
		.wdata (weight_q),
		.re    (ctl.exec),
		.raddr (QAW'(idx)),
		.rdata (top_rd)
	);

	hffa_ram #(
		.WIDTH (WEIGHT_W),
		.DEPTH (QD)
	) u_side_ram (
		.clk   (clk),
		.we    (load_we && face_q),
		.waddr (QAW'(entry_q)),
		.wdata (weight_q),
		.re    (ctl.exec),
		.raddr (QAW'(idx)),
		.rdata (side_rd)
	);

	assign w_sel   = face_s2 ? side_rd : top_rd;
	assign acc     = {1'b0, sum_rd} + (SUM_W + 1)'(w_sel);
	assign new_sum = acc[SUM_W] ? '1 : acc[SUM_W-1:0];

	assign sum_we    = ctl.clr_run || (ctl.finish && do_acc_s2);
	assign sum_waddr = ctl.clr_run ? clr_cnt_q : slot_s2;
	assign sum_wdata = ctl.clr_run ? '0 : new_sum;

	hffa_ram #(
		.WIDTH (SUM_W),
		.DEPTH (MAX_PATCHES)
	) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.re    (ctl.exec),
		.raddr (slot),
		.rdata (sum_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctl.finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			out_status_q <= status_s2;
			out_sum_q    <= rd_ok_s2 ? sum_rd : '0;
		end
	end

	assign m_tvalid     = m_tvalid_q;
	assign m_tdata      = {2'b00, out_sum_q, out_status_q};
	assign sts.cmd      = cmd_q;
	assign sts.clr_last = clr_last;
	assign sts.out_free = !m_tvalid_q || m_tready;

endmodule

`default_nettype wire

// ----- rtl/core/hemicube_form_factor_accumulator.sv -----
`default_nettype none

// Hemicube form factor accumulator. Each item is a command: clear all patch sums, load one
// quarter-table weight, accumulate one item-buffer pixel into its patch sum, or read one sum;
// every item yields exactly one result with a status and, for a good read, the Q4.32 sum.
// Load, accumulate and read items pass the accept, check and memory read, and update and
// result steps, set by the read-modify-write of the single-read-port sum memory; a result
// also waits while an earlier one is still held at the output. A clear item clears one
// sum memory entry per cycle over all MAX_PATCHES entries. After reset the same clearing
// pass runs before the first item is accepted; register writes are taken at any time.
// The next item can be accepted while the previous result waits.

module hemicube_form_factor_accumulator #(
	parameter int MAX_RES     = hffa_pkg::DEF_MAX_RES,
	parameter int MAX_PATCHES = hffa_pkg::DEF_MAX_PATCHES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// row, col, pixel_color, entry_index, weight_value, zero padding
	input  logic [hffa_pkg::IN_DATA_W-1:0]    s_tdata,
	// cmd, face_kind
	input  logic [hffa_pkg::IN_USER_W-1:0]    s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// status, sum_value, zero padding
	output logic [hffa_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [hffa_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [hffa_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [hffa_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);

	import hffa_pkg::*;

	hffa_cfg_t cfg;
	hffa_ctl_t ctl;
	hffa_sts_t sts;

	hffa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.ctl      (ctl),
		.sts      (sts)
	);

	hffa_dpath #(
		.MAX_RES     (MAX_RES),
		.MAX_PATCHES (MAX_PATCHES)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.cfg      (cfg),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire
